### rtl/qwrw_pkg.sv
// Package for the wrench rotate watchdog: field widths, queue entry and
// sequencer state types. No dependencies.
package qwrw_pkg;
   localparam int unsigned WideW = 32;
   localparam int unsigned QuatW = 16;
   localparam int unsigned CountW = 16;
   localparam logic [CountW-1:0] TimeoutReset = 16'd100;
   localparam logic [CountW-1:0] CountMax = 16'hFFFF;
   localparam int unsigned AccW = 72;

   typedef struct packed {
      logic                    timed_out;
      logic signed [QuatW-1:0] qx;
      logic signed [QuatW-1:0] qy;
      logic signed [QuatW-1:0] qz;
      logic signed [QuatW-1:0] qw;
      logic signed [WideW-1:0] f0;
      logic signed [WideW-1:0] f1;
      logic signed [WideW-1:0] f2;
      logic signed [WideW-1:0] t0;
      logic signed [WideW-1:0] t1;
      logic signed [WideW-1:0] t2;
   } job_type;

   typedef enum logic [2:0] {
      ST_IDLE, ST_PROD, ST_ENTRY, ST_MAC, ST_ROUND, ST_OUT
   } seq_type;
endpackage

### rtl/qwrw_front.sv
// Front end: accepts beats, keeps the stored wrench and silence counter,
// classifies ticks and pushes jobs into a two-entry queue. Uses qwrw_pkg.
module qwrw_front import qwrw_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CountW-1:0]       csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_opcode,
   input  logic signed [WideW-1:0] req_force_x,
   input  logic signed [WideW-1:0] req_force_y,
   input  logic signed [WideW-1:0] req_force_z,
   input  logic signed [WideW-1:0] req_torque_x,
   input  logic signed [WideW-1:0] req_torque_y,
   input  logic signed [WideW-1:0] req_torque_z,
   input  logic signed [QuatW-1:0] req_quat_x,
   input  logic signed [QuatW-1:0] req_quat_y,
   input  logic signed [QuatW-1:0] req_quat_z,
   input  logic signed [QuatW-1:0] req_quat_w,
   output logic                    job_valid,
   output job_type                 job_data,
   input  logic                    job_pop
);
   logic [CountW-1:0] timeout_ff;
   logic [CountW-1:0] count_ff, count_in;
   logic signed [WideW-1:0] bf_ff [3];
   logic signed [WideW-1:0] bt_ff [3];
   job_type q_ff [2];
   logic [1:0] fill_ff, fill_in;
   logic rd_ff, wr_ff;
   logic take, push;
   job_type job_in;

   assign req_stall = (fill_ff == 2'd2);
   assign take = req_valid && !req_stall;
   assign push = take && !req_opcode;
   assign count_in = (count_ff == CountMax) ? count_ff : count_ff + 1'b1;

   always_comb begin
      job_in.timed_out = count_in > timeout_ff;
      job_in.qx = req_quat_x;
      job_in.qy = req_quat_y;
      job_in.qz = req_quat_z;
      job_in.qw = req_quat_w;
      job_in.f0 = bf_ff[0];
      job_in.f1 = bf_ff[1];
      job_in.f2 = bf_ff[2];
      job_in.t0 = bt_ff[0];
      job_in.t1 = bt_ff[1];
      job_in.t2 = bt_ff[2];
   end

   always_comb begin
      fill_in = fill_ff;
      if (push && !job_pop) begin
         fill_in = fill_ff + 2'd1;
      end else if (!push && job_pop) begin
         fill_in = fill_ff - 2'd1;
      end
   end

   assign job_valid = (fill_ff != 2'd0);
   assign job_data = q_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= TimeoutReset;
         count_ff <= '0;
         fill_ff <= '0;
         rd_ff <= 1'b0;
         wr_ff <= 1'b0;
         for (int i = 0; i < 3; i++) begin
            bf_ff[i] <= '0;
            bt_ff[i] <= '0;
         end
      end else begin
         if (csr_write_enable) begin
            timeout_ff <= csr_write_data;
         end
         fill_ff <= fill_in;
         if (job_pop) begin
            rd_ff <= !rd_ff;
         end
         if (take && req_opcode) begin
            count_ff <= '0;
            bf_ff[0] <= req_force_x;
            bf_ff[1] <= req_force_y;
            bf_ff[2] <= req_force_z;
            bt_ff[0] <= req_torque_x;
            bt_ff[1] <= req_torque_y;
            bt_ff[2] <= req_torque_z;
         end else if (push) begin
            count_ff <= count_in;
         end
         if (push) begin
            wr_ff <= !wr_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= job_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) fill_ff <= 2'd2)
      else $error("queue overfilled");
   assert property (@(posedge clock) disable iff (reset)
      job_pop |-> job_valid) else $error("pop from empty queue");
   assert property (@(posedge clock) disable iff (reset)
      (take && req_opcode) |=> count_ff == '0) else $error("count not cleared");
endmodule

### rtl/qwrw_back.sv
// Back end: shared multiplier sequencer forming the rotation matrix and the
// rotated wrench, rounding, saturation and result register. Uses qwrw_pkg.
module qwrw_back import qwrw_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    job_valid,
   input  job_type                 job_data,
   output logic                    job_pop,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WideW-1:0] rsp_world_force_x,
   output logic signed [WideW-1:0] rsp_world_force_y,
   output logic signed [WideW-1:0] rsp_world_force_z,
   output logic signed [WideW-1:0] rsp_world_torque_x,
   output logic signed [WideW-1:0] rsp_world_torque_y,
   output logic signed [WideW-1:0] rsp_world_torque_z,
   output logic                    rsp_timed_out
);
   seq_type state_ff, state_in;
   job_type job_ff;
   logic [3:0] idx_ff, idx_in;
   logic signed [31:0] prod_ff [9];
   logic signed [32:0] mat_ff [9];
   logic signed [AccW-1:0] acc_ff, acc_in;
   logic signed [WideW-1:0] res_ff [6];
   logic [2:0] row_ff;
   logic [1:0] col_ff;
   logic signed [QuatW-1:0] pa, pb;
   logic signed [31:0] p16;
   logic signed [WideW-1:0] bvec;
   logic signed [63:0] p64;
   logic signed [AccW-1:0] rounded;
   logic signed [AccW-30:0] shifted;
   logic signed [WideW-1:0] sat;
   logic out_valid_ff;
   logic tout_ff;
   logic [2:0] row_sel;

   // product order: xx yy zz xy xz yz wx wy wz
   always_comb begin
      unique case (idx_ff)
         4'd0: begin pa = job_ff.qx; pb = job_ff.qx; end
         4'd1: begin pa = job_ff.qy; pb = job_ff.qy; end
         4'd2: begin pa = job_ff.qz; pb = job_ff.qz; end
         4'd3: begin pa = job_ff.qx; pb = job_ff.qy; end
         4'd4: begin pa = job_ff.qx; pb = job_ff.qz; end
         4'd5: begin pa = job_ff.qy; pb = job_ff.qz; end
         4'd6: begin pa = job_ff.qw; pb = job_ff.qx; end
         4'd7: begin pa = job_ff.qw; pb = job_ff.qy; end
         default: begin pa = job_ff.qw; pb = job_ff.qz; end
      endcase
   end
   assign p16 = 32'(pa * pb);

   assign row_sel = (row_ff >= 3'd3) ? row_ff - 3'd3 : row_ff;
   always_comb begin
      if (row_ff < 3'd3) begin
         unique case (col_ff)
            2'd0: bvec = job_ff.f0;
            2'd1: bvec = job_ff.f1;
            default: bvec = job_ff.f2;
         endcase
      end else begin
         unique case (col_ff)
            2'd0: bvec = job_ff.t0;
            2'd1: bvec = job_ff.t1;
            default: bvec = job_ff.t2;
         endcase
      end
   end
   assign p64 = 64'(mat_ff[4'(row_sel * 3'd3) + 4'(col_ff)]) * 64'(bvec);
   assign acc_in = acc_ff + AccW'(p64);
   assign rounded = acc_ff + (AccW'(1) <<< 28);
   assign shifted = rounded[AccW-1:29];
   always_comb begin
      if (shifted > (AccW-29)'(32'sh7FFFFFFF)) begin
         sat = 32'sh7FFFFFFF;
      end else if (shifted < -(AccW-29)'(33'sh080000000)) begin
         sat = 32'sh80000000;
      end else begin
         sat = shifted[WideW-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (job_valid && !job_data.timed_out) begin
               state_in = ST_PROD;
            end else if (job_valid) begin
               state_in = ST_OUT;
            end
            idx_in = '0;
         end
         ST_PROD: begin
            idx_in = idx_ff + 4'd1;
            if (idx_ff == 4'd8) begin
               state_in = ST_ENTRY;
            end
         end
         ST_ENTRY: state_in = ST_MAC;
         ST_MAC: if (col_ff == 2'd2) state_in = ST_ROUND;
         ST_ROUND: state_in = (row_ff == 3'd5) ? ST_OUT : ST_MAC;
         ST_OUT: if (!out_valid_ff) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   assign job_pop = (state_ff == ST_IDLE) && job_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         idx_ff <= idx_in;
         if (state_ff == ST_OUT && !out_valid_ff) begin
            out_valid_ff <= 1'b1;
         end else if (out_valid_ff && !rsp_stall) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         job_ff <= job_data;
         row_ff <= '0;
         col_ff <= '0;
         acc_ff <= '0;
         tout_ff <= job_data.timed_out;
         for (int i = 0; i < 6; i++) begin
            res_ff[i] <= '0;
         end
      end
      if (state_ff == ST_PROD) begin
         prod_ff[idx_ff] <= p16;
      end
      if (state_ff == ST_ENTRY) begin
         mat_ff[0] <= 33'sh020000000 - (33'(prod_ff[1]) + 33'(prod_ff[2]));
         mat_ff[1] <= 33'(prod_ff[3]) - 33'(prod_ff[8]);
         mat_ff[2] <= 33'(prod_ff[4]) + 33'(prod_ff[7]);
         mat_ff[3] <= 33'(prod_ff[3]) + 33'(prod_ff[8]);
         mat_ff[4] <= 33'sh020000000 - (33'(prod_ff[0]) + 33'(prod_ff[2]));
         mat_ff[5] <= 33'(prod_ff[5]) - 33'(prod_ff[6]);
         mat_ff[6] <= 33'(prod_ff[4]) - 33'(prod_ff[7]);
         mat_ff[7] <= 33'(prod_ff[5]) + 33'(prod_ff[6]);
         mat_ff[8] <= 33'sh020000000 - (33'(prod_ff[0]) + 33'(prod_ff[1]));
      end
      if (state_ff == ST_MAC) begin
         acc_ff <= acc_in;
         col_ff <= (col_ff == 2'd2) ? 2'd0 : col_ff + 2'd1;
      end
      if (state_ff == ST_ROUND) begin
         res_ff[row_ff] <= sat;
         acc_ff <= '0;
         row_ff <= row_ff + 3'd1;
      end
      if (state_ff == ST_OUT && !out_valid_ff) begin
         rsp_world_force_x <= res_ff[0];
         rsp_world_force_y <= res_ff[1];
         rsp_world_force_z <= res_ff[2];
         rsp_world_torque_x <= res_ff[3];
         rsp_world_torque_y <= res_ff[4];
         rsp_world_torque_z <= res_ff[5];
         rsp_timed_out <= tout_ff;
      end
   end

   assign rsp_valid = out_valid_ff;

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> rsp_valid) else $error("result dropped");
   assert property (@(posedge clock) disable iff (reset)
      job_pop |-> state_ff == ST_IDLE) else $error("pop while busy");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_MAC) |-> row_ff < 3'd6) else $error("row overrun");
endmodule

### rtl/quaternion_wrench_rotate_watchdog_core.sv
// Top level of the wrench rotate watchdog: front end, job queue and back end.
// Uses qwrw_pkg, qwrw_front and qwrw_back.
//
// Input channel req_*: a beat with opcode 1 stores a body force and torque
// and clears the silence counter, giving no result. A beat with opcode 0 is
// a tick carrying an attitude quaternion; it advances the counter and gives
// one rsp_* beat: the rotated force and torque, or zeros with timed_out set
// when the counter passes csr timeout.
// A timed-out tick skips the multipliers; a rotated tick is paced by one
// 16x16 multiplier over nine quaternion products and one 33x32
// multiplier over eighteen matrix-vector products, three per output plus
// one rounding step each. One tick is in the back end at a time, so the
// back end takes no new tick until it has registered the last result;
// the front end holds two queued ticks and takes messages meanwhile.
// Reset clears the stored wrench, the counter and the queue and sets the
// timeout to 100. When rsp_stall is high the result beat holds, the back
// end waits, the queue fills and req_stall rises.
module quaternion_wrench_rotate_watchdog_core import qwrw_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_write_enable,
   input  logic [CountW-1:0]       csr_write_data,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_opcode,
   input  logic signed [WideW-1:0] req_force_x,
   input  logic signed [WideW-1:0] req_force_y,
   input  logic signed [WideW-1:0] req_force_z,
   input  logic signed [WideW-1:0] req_torque_x,
   input  logic signed [WideW-1:0] req_torque_y,
   input  logic signed [WideW-1:0] req_torque_z,
   input  logic signed [QuatW-1:0] req_quat_x,
   input  logic signed [QuatW-1:0] req_quat_y,
   input  logic signed [QuatW-1:0] req_quat_z,
   input  logic signed [QuatW-1:0] req_quat_w,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic signed [WideW-1:0] rsp_world_force_x,
   output logic signed [WideW-1:0] rsp_world_force_y,
   output logic signed [WideW-1:0] rsp_world_force_z,
   output logic signed [WideW-1:0] rsp_world_torque_x,
   output logic signed [WideW-1:0] rsp_world_torque_y,
   output logic signed [WideW-1:0] rsp_world_torque_z,
   output logic                    rsp_timed_out
);
   logic job_valid, job_pop;
   job_type job_data;

   qwrw_front u_front (
      .clock, .reset, .csr_write_enable, .csr_write_data,
      .req_valid, .req_stall, .req_opcode,
      .req_force_x, .req_force_y, .req_force_z,
      .req_torque_x, .req_torque_y, .req_torque_z,
      .req_quat_x, .req_quat_y, .req_quat_z, .req_quat_w,
      .job_valid, .job_data, .job_pop
   );

   qwrw_back u_back (
      .clock, .reset, .job_valid, .job_data, .job_pop,
      .rsp_valid, .rsp_stall,
      .rsp_world_force_x, .rsp_world_force_y, .rsp_world_force_z,
      .rsp_world_torque_x, .rsp_world_torque_y, .rsp_world_torque_z,
      .rsp_timed_out
   );
endmodule

### dv/tb_quaternion_wrench_rotate_watchdog_core.sv
// Self-checking testbench for quaternion_wrench_rotate_watchdog_core: a directed table,
// then random wrench/tick traffic with bursty input and patterned output stall.
// Depends on qwrw_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_quaternion_wrench_rotate_watchdog_core import qwrw_pkg::*;;

   localparam bit OP_TICK = 1'b0;
   localparam bit OP_WRENCH = 1'b1;
   localparam int DRAIN_CYCLES = 60;

   typedef struct {
      bit                     opcode;
      logic signed [WideW-1:0] force_v [3];
      logic signed [WideW-1:0] torque_v [3];
      logic signed [QuatW-1:0] quat_v [4];   // x y z w
   } beat_t;

   typedef struct {
      logic signed [WideW-1:0] world_force [3];
      logic signed [WideW-1:0] world_torque [3];
      logic                    timed_out;
   } wrench_out_t;

   typedef struct {
      beat_t       item;
      bit          has_fixed;
      wrench_out_t fixed;
      bit          set_timeout;
      logic [CountW-1:0] timeout_value;
   } table_row_t;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CountW-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic req_opcode = 1'b0;
   logic signed [WideW-1:0] req_force_x = '0, req_force_y = '0, req_force_z = '0;
   logic signed [WideW-1:0] req_torque_x = '0, req_torque_y = '0, req_torque_z = '0;
   logic signed [QuatW-1:0] req_quat_x = '0, req_quat_y = '0, req_quat_z = '0;
   logic signed [QuatW-1:0] req_quat_w = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [WideW-1:0] rsp_world_force_x, rsp_world_force_y, rsp_world_force_z;
   logic signed [WideW-1:0] rsp_world_torque_x, rsp_world_torque_y, rsp_world_torque_z;
   logic rsp_timed_out;

   quaternion_wrench_rotate_watchdog_core DUT (.*);

   always #5 clock = ~clock;

   // predictor state
   logic signed [WideW-1:0] held_force [3];
   logic signed [WideW-1:0] held_torque [3];
   logic [CountW-1:0] silence_ticks;
   logic [CountW-1:0] timeout_limit;

   wrench_out_t pending_wrench[$];
   int mismatches = 0;
   bit stall_enable = 1'b1;

   function automatic logic signed [WideW-1:0] rotate_row(
         input logic signed [63:0] row [3], input logic signed [WideW-1:0] b [3]);
      logic signed [127:0] acc;
      logic signed [127:0] q;
      acc = 0;
      for (int k = 0; k < 3; k++) acc += 128'(row[k]) * 128'(b[k]);
      acc += 128'sd1 <<< 28;
      q = acc >>> 29;
      if (q > 128'sd2147483647) return 32'sh7FFFFFFF;
      if (q < -128'sd2147483648) return 32'sh80000000;
      return q[31:0];
   endfunction

   function automatic wrench_out_t rotate_wrench(input beat_t it);
      wrench_out_t r;
      logic signed [63:0] x, y, z, w;
      logic signed [63:0] m [3][3];
      logic signed [63:0] row [3];
      x = it.quat_v[0]; y = it.quat_v[1]; z = it.quat_v[2]; w = it.quat_v[3];
      m[0][0] = (64'sd1 <<< 29) - (y*y + z*z);
      m[0][1] = x*y - w*z;
      m[0][2] = x*z + w*y;
      m[1][0] = x*y + w*z;
      m[1][1] = (64'sd1 <<< 29) - (x*x + z*z);
      m[1][2] = y*z - w*x;
      m[2][0] = x*z - w*y;
      m[2][1] = y*z + w*x;
      m[2][2] = (64'sd1 <<< 29) - (x*x + y*y);
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) row[k] = m[i][k];
         r.world_force[i] = rotate_row(row, held_force);
         r.world_torque[i] = rotate_row(row, held_torque);
      end
      r.timed_out = 1'b0;
      return r;
   endfunction

   // returns 1 when a result is due
   function automatic bit advance_watchdog(input beat_t it, output wrench_out_t r);
      if (it.opcode == OP_WRENCH) begin
         held_force = it.force_v;
         held_torque = it.torque_v;
         silence_ticks = '0;
         return 1'b0;
      end
      if (silence_ticks != CountMax) silence_ticks++;
      if (silence_ticks > timeout_limit) begin
         for (int k = 0; k < 3; k++) begin
            r.world_force[k] = '0;
            r.world_torque[k] = '0;
         end
         r.timed_out = 1'b1;
      end else begin
         r = rotate_wrench(it);
      end
      return 1'b1;
   endfunction

   function automatic beat_t random_beat(input bit op);
      beat_t b;
      int mode;
      b.opcode = op;
      for (int k = 0; k < 3; k++) begin
         mode = $urandom_range(0, 9);
         b.force_v[k] = mode == 0 ? 32'sh7FFFFFFF : mode == 1 ? 32'sh80000000 :
                        mode < 6 ? $signed($urandom_range(0, 2000000)) - 1000000 :
                        $urandom;
         mode = $urandom_range(0, 9);
         b.torque_v[k] = mode == 0 ? 32'sh7FFFFFFF : mode == 1 ? 32'sh80000000 :
                         mode < 6 ? $signed($urandom_range(0, 2000000)) - 1000000 :
                         $urandom;
      end
      for (int k = 0; k < 4; k++) b.quat_v[k] = $urandom;
      if ($urandom_range(0, 2) != 0) begin
         // smaller quaternion: halve each component to narrow the range of the products
         for (int k = 0; k < 4; k++) b.quat_v[k] = b.quat_v[k] >>> 1;
      end
      return b;
   endfunction

   task automatic write_timeout(input logic [CountW-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      timeout_limit = value;
   endtask

   task automatic wait_idle();
      while (pending_wrench.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic send_beat(input beat_t b, input bit check_fixed, input wrench_out_t fx);
      wrench_out_t r;
      req_valid <= 1'b1;
      req_opcode <= b.opcode;
      req_force_x <= b.force_v[0]; req_force_y <= b.force_v[1];
      req_force_z <= b.force_v[2];
      req_torque_x <= b.torque_v[0]; req_torque_y <= b.torque_v[1];
      req_torque_z <= b.torque_v[2];
      req_quat_x <= b.quat_v[0]; req_quat_y <= b.quat_v[1];
      req_quat_z <= b.quat_v[2]; req_quat_w <= b.quat_v[3];
      do @(posedge clock); while (req_stall);
      if (advance_watchdog(b, r)) begin
         if (check_fixed && r != fx) begin
            mismatches++;
            if (mismatches <= 10)
               $display("table row mismatch at %0t: exp F0 %0d to=%0b got F0 %0d to=%0b",
                  $realtime, fx.world_force[0], fx.timed_out, r.world_force[0],
                  r.timed_out);
         end
         pending_wrench.push_back(r);
      end
   endtask

   task automatic send_gap();
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clock);
   endtask

   // result checking
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         wrench_out_t got, exp_r;
         got.world_force[0] = rsp_world_force_x;
         got.world_force[1] = rsp_world_force_y;
         got.world_force[2] = rsp_world_force_z;
         got.world_torque[0] = rsp_world_torque_x;
         got.world_torque[1] = rsp_world_torque_y;
         got.world_torque[2] = rsp_world_torque_z;
         got.timed_out = rsp_timed_out;
         if (pending_wrench.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat at %0t", $realtime);
         end else begin
            exp_r = pending_wrench.pop_front();
            if (got !== exp_r) begin
               mismatches++;
               if (mismatches <= 10)
                  $display({"mismatch at %0t: exp F(%0d %0d %0d) T(%0d %0d %0d) to=%0b",
                            " got F(%0d %0d %0d) T(%0d %0d %0d) to=%0b"},
                     $realtime, exp_r.world_force[0], exp_r.world_force[1],
                     exp_r.world_force[2], exp_r.world_torque[0], exp_r.world_torque[1],
                     exp_r.world_torque[2], exp_r.timed_out, got.world_force[0],
                     got.world_force[1], got.world_force[2], got.world_torque[0],
                     got.world_torque[1], got.world_torque[2], got.timed_out);
            end
         end
      end
   end

   // receiver stall pattern: runs of stall and of free flow
   initial begin
      int phase;
      phase = 0;
      forever begin
         @(posedge clock);
         phase = (phase + 1) % 64;
         rsp_stall <= stall_enable && (phase < 24) && ($urandom_range(0, 2) != 0);
      end
   end

   initial begin
      #50ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      table_row_t rows[$];
      table_row_t row;
      beat_t b;
      wrench_out_t zero_out, id_out;
      int burst, sent;
      logic [CountW-1:0] limits [6];

      for (int k = 0; k < 3; k++) begin
         held_force[k] = '0;
         held_torque[k] = '0;
         zero_out.world_force[k] = '0;
         zero_out.world_torque[k] = '0;
      end
      zero_out.timed_out = 1'b0;
      silence_ticks = '0;
      timeout_limit = TimeoutReset;
      limits = '{16'd3, 16'd65535, 16'd1, 16'd40, 16'd65534, 16'd100};

      // directed table
      row = '{default: '0};
      row.item = random_beat(OP_TICK);
      row.item.quat_v = '{16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF};
      row.has_fixed = 1'b1; row.fixed = zero_out;      // zero wrench after reset
      rows.push_back(row);
      row = '{default: '0};
      row.item.opcode = OP_WRENCH;
      row.item.force_v = '{32'sh00010000, 32'sh7FFFFFFF, 32'sh80000000};
      row.item.torque_v = '{32'sh80000000, 32'sh00000000, 32'sh7FFFFFFF};
      row.item.quat_v = '{16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000};
      rows.push_back(row);
      row = '{default: '0};
      row.item.opcode = OP_TICK;                        // zero quaternion: identity
      id_out.world_force = '{32'sh00010000, 32'sh7FFFFFFF, 32'sh80000000};
      id_out.world_torque = '{32'sh80000000, 32'sh00000000, 32'sh7FFFFFFF};
      id_out.timed_out = 1'b0;
      row.has_fixed = 1'b1; row.fixed = id_out;
      rows.push_back(row);
      foreach (row.item.quat_v[k]) begin
         row = '{default: '0};
         row.item.opcode = OP_TICK;
         row.item.quat_v[k] = 16'sh8000;
         rows.push_back(row);
         row.item.quat_v[k] = 16'sh7FFF;
         rows.push_back(row);
      end
      row = '{default: '0};
      row.item = random_beat(OP_TICK);
      row.item.quat_v = '{16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000};
      rows.push_back(row);
      // zero timeout: every tick times out, the wrench is kept
      row = '{default: '0};
      row.set_timeout = 1'b1; row.timeout_value = 16'd0;
      row.item.opcode = OP_TICK;
      row.has_fixed = 1'b1; row.fixed = zero_out; row.fixed.timed_out = 1'b1;
      rows.push_back(row);
      row.set_timeout = 1'b0;
      rows.push_back(row);
      row = '{default: '0};
      row.set_timeout = 1'b1; row.timeout_value = 16'd3;
      row.item.opcode = OP_TICK;
      row.item.quat_v = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh4000};
      rows.push_back(row);

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (rows[i]) begin
         if (rows[i].set_timeout) begin
            req_valid <= 1'b0;
            wait_idle();
            write_timeout(rows[i].timeout_value);
         end
         send_beat(rows[i].item, rows[i].has_fixed, rows[i].fixed);
      end
      req_valid <= 1'b0;

      // random phases across timeout settings, extremes included
      foreach (limits[p]) begin
         wait_idle();
         write_timeout(limits[p]);
         stall_enable = (p != 2);
         sent = 0;
         while (sent < 200) begin
            burst = $urandom_range(1, 12);
            for (int j = 0; j < burst; j++) begin
               b = random_beat(($urandom_range(0, 3 + 4 * (p % 2)) == 0) ? OP_WRENCH : OP_TICK);
               send_beat(b, 1'b0, zero_out);
               sent++;
            end
            if ($urandom_range(0, 3) == 0) send_gap();
            if (sent > 100 && sent < 110) begin
               req_valid <= 1'b0;
               do @(posedge clock); while (pending_wrench.size() != 0);
            end
         end
         req_valid <= 1'b0;
      end

      // largest timeout settings with an identity quaternion
      wait_idle();
      write_timeout(16'd65535);
      stall_enable = 1'b0;
      b = random_beat(OP_TICK);
      b.opcode = OP_TICK;
      b.quat_v = '{16'sh0000, 16'sh0000, 16'sh0000, 16'sh0000};
      repeat (20) send_beat(b, 1'b0, zero_out);
      req_valid <= 1'b0;
      wait_idle();
      write_timeout(16'd65534);
      repeat (20) send_beat(b, 1'b0, zero_out);
      req_valid <= 1'b0;

      wait_idle();
      if (mismatches == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end
endmodule
